// ----- design/mspt_pkg.sv -----
`timescale 1ns / 1ps
package mspt_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_KILL  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  localparam int unsigned IvlW     = 32;
  localparam int unsigned ElapsedW = 33;
  localparam int unsigned TagW     = 32;
  localparam int unsigned StepW    = 16;
  localparam logic [StepW-1:0] StepReset = 16'd500;

  // One slot as stored in the slot memory
  typedef struct packed {
    logic [IvlW-1:0]     interval;
    logic [ElapsedW-1:0] elapsed;
    logic [TagW-1:0]     tag;
  } slot_entry_t;

endpackage

// ----- design/mspt_slot_mem.sv -----
`timescale 1ns / 1ps
module mspt_slot_mem
  import mspt_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  slot_entry_t      wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output slot_entry_t      rdata_o
);

  slot_entry_t mem_q [Depth];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/mspt_regs.sv -----
`timescale 1ns / 1ps
module mspt_regs
  import mspt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic [StepW-1:0] tick_step_o
);

  logic [StepW-1:0] step_q, step_d;
  logic             sel_step;

  assign sel_step = (paddr[2] == 1'b0);

  always_comb begin
    step_d = step_q;
    if (psel && penable && pwrite && sel_step) begin
      step_d = pwdata[StepW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
    end else begin
      step_q <= step_d;
    end
  end

  assign prdata      = sel_step ? 32'(step_q) : 32'd0;
  assign tick_step_o = step_q;

endmodule

// ----- design/multi_slot_periodic_timer_core.sv -----
`timescale 1ns / 1ps
// Start, kill and clear words are taken in idle; the block stays ready for the next word.
// A tick sweeps the slot memory one slot per cycle, with the input not ready until the
// sweep ends; a full output register stalls the sweep.
// A report is held until the next slot fires, the final one until the sweep is done.
// Reset (async, active low) disarms all slots and sets tick_step to 500; no clearing pass.
module multi_slot_periodic_timer_core
  import mspt_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  slot_index_i,
  input  logic [31:0] interval_ms_i,
  input  logic [31:0] user_tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  fired_slot_o,
  output logic [31:0] fired_tag_o,
  output logic        last_of_tick_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [StepW-1:0] tick_step;
  logic             accept;
  logic             idx_ok;
  logic [IdxW-1:0]  in_idx;

  logic             armed_q [SLOTS];
  logic [CntW-1:0]  rd_cnt_q, rd_cnt_d;
  logic             s1_v_q, s1_v_d;
  logic             s1_armed_q, s1_armed_d;
  logic [IdxW-1:0]  s1_idx_q, s1_idx_d;

  logic             pend_v_q, pend_v_d;
  logic [IdxW-1:0]  pend_idx_q, pend_idx_d;
  logic [TagW-1:0]  pend_tag_q, pend_tag_d;

  logic             out_v_q, out_v_d;
  logic [3:0]       out_slot_q, out_slot_d;
  logic [TagW-1:0]  out_tag_q, out_tag_d;
  logic             out_last_q, out_last_d;

  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  slot_entry_t      mem_wdata, mem_rdata;

  logic [ElapsedW-1:0] sum;
  logic             fire, stall, adv, issue, out_free, push_mid, push_fin;

  mspt_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .tick_step_o (tick_step)
  );

  assign pready = 1'b1;

  mspt_slot_mem #(
    .Depth (SLOTS),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign idx_ok     = (32'(slot_index_i) < SLOTS);
  assign in_idx     = IdxW'(slot_index_i);

  // eval stage: slot data arrived from memory
  assign sum      = mem_rdata.elapsed + ElapsedW'(tick_step);
  assign fire     = s1_v_q && s1_armed_q && (sum >= ElapsedW'(mem_rdata.interval));
  assign out_free = !out_v_q || out_ready_i;
  // a new fire pushes the held report out; hold the sweep if there is no room
  assign stall    = fire && pend_v_q && !out_free;
  assign adv      = (state_q == ST_SWEEP) && !stall;
  assign issue    = adv && (rd_cnt_q < CntW'(SLOTS));
  assign push_mid = adv && fire && pend_v_q;
  assign push_fin = (state_q == ST_FLUSH) && pend_v_q && out_free;

  assign mem_re    = issue;
  assign mem_raddr = rd_cnt_q[IdxW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_idx_q;
    mem_wdata = mem_rdata;
    if (accept && operation_i == OP_START && idx_ok) begin
      mem_we             = 1'b1;
      mem_waddr          = in_idx;
      mem_wdata.interval = interval_ms_i;
      mem_wdata.elapsed  = '0;
      mem_wdata.tag      = user_tag_i;
    end else if (adv && s1_v_q && s1_armed_q) begin
      mem_we            = 1'b1;
      mem_wdata.elapsed = fire ? '0 : sum;
    end
  end

  always_comb begin
    state_d    = state_q;
    rd_cnt_d   = rd_cnt_q;
    s1_v_d     = s1_v_q;
    s1_armed_d = s1_armed_q;
    s1_idx_d   = s1_idx_q;
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    pend_tag_d = pend_tag_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && operation_i == OP_TICK) begin
          rd_cnt_d = '0;
          s1_v_d   = 1'b0;
          state_d  = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (adv) begin
          s1_v_d = issue;
          if (issue) begin
            s1_idx_d   = rd_cnt_q[IdxW-1:0];
            s1_armed_d = armed_q[rd_cnt_q[IdxW-1:0]];
            rd_cnt_d   = rd_cnt_q + CntW'(1);
          end else begin
            state_d = ST_FLUSH;
          end
          if (fire) begin
            pend_v_d   = 1'b1;
            pend_idx_d = s1_idx_q;
            pend_tag_d = mem_rdata.tag;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_v_d    = out_v_q;
    out_slot_d = out_slot_q;
    out_tag_d  = out_tag_q;
    out_last_d = out_last_q;
    if (push_mid || push_fin) begin
      out_v_d    = 1'b1;
      out_slot_d = 4'(pend_idx_q);
      out_tag_d  = pend_tag_q;
      out_last_d = push_fin;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_cnt_q <= '0;
      s1_v_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
      s1_v_q   <= s1_v_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_armed_q <= s1_armed_d;
    s1_idx_q   <= s1_idx_d;
    pend_idx_q <= pend_idx_d;
    pend_tag_q <= pend_tag_d;
    out_slot_q <= out_slot_d;
    out_tag_q  <= out_tag_d;
    out_last_q <= out_last_d;
  end

  // armed flags live in flops so reset clears them at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        armed_q[i] <= 1'b0;
      end
    end else if (accept) begin
      case (operation_i)
        OP_START: begin
          if (idx_ok) begin
            armed_q[in_idx] <= 1'b1;
          end
        end
        OP_KILL: begin
          if (idx_ok) begin
            armed_q[in_idx] <= 1'b0;
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < SLOTS; i++) begin
            armed_q[i] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o    = out_v_q;
  assign fired_slot_o   = out_slot_q;
  assign fired_tag_o    = out_tag_q;
  assign last_of_tick_o = out_last_q;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import mspt_pkg::*;

  localparam int unsigned NSLOTS = 16;
  localparam int QuietLimit = 4000;
  localparam int SettleCycles = 40;
  localparam int HoldCycles = 300;
  localparam int ReportMax = 10;
  localparam logic [2:0] ADDR_TICK_STEP = 3'd0;

  typedef struct packed {
    op_e         op;
    logic [3:0]  slot;
    logic [31:0] ivl;
    logic [31:0] tag;
  } timer_cmd_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic [31:0] tag;
    logic        last;
  } fire_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = '0;
  logic [3:0]  slot_index_i = '0;
  logic [31:0] interval_ms_i = '0;
  logic [31:0] user_tag_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  fired_slot_o;
  logic [31:0] fired_tag_o;
  logic        last_of_tick_o;

  multi_slot_periodic_timer_core #(
    .SLOTS(NSLOTS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .slot_index_i   (slot_index_i),
    .interval_ms_i  (interval_ms_i),
    .user_tag_i     (user_tag_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .fired_slot_o   (fired_slot_o),
    .fired_tag_o    (fired_tag_o),
    .last_of_tick_o (last_of_tick_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the slot table
  logic [NSLOTS-1:0] tmr_armed = '0;
  logic [31:0]       tmr_ivl     [NSLOTS];
  logic [32:0]       tmr_elapsed [NSLOTS];
  logic [31:0]       tmr_tag     [NSLOTS];
  logic [15:0]       tmr_step = StepReset;

  timer_cmd_t   pending_cmds[$];
  fire_report_t due_reports[$];

  int  n_cmds_queued = 0;
  int  n_cmds_taken = 0;
  int  n_ticks = 0;
  int  n_reports = 0;
  int  n_mismatch = 0;
  int  n_settings = 0;
  int  quiet_cycles = 0;
  bit  tx_gaps_on = 1'b1;
  bit  rx_stalls_on = 1'b1;
  bit  pressure_on = 1'b0;
  bit  hold_done = 1'b0;
  int  tx_wait = 0;
  int  tx_gap;
  int  rx_wait = 0;
  int  rx_next;
  timer_cmd_t next_cmd;

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    n_mismatch++;
    if (n_mismatch <= ReportMax)
      $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
  endfunction

  // Applies one accepted word to the shadow table; ticks queue their fire reports.
  function automatic void run_timer_cmd(op_e op, logic [3:0] slot, logic [31:0] ivl,
                                        logic [31:0] tag);
    logic [32:0]       sum;
    logic [NSLOTS-1:0] fired;
    int                last_s;
    fired = '0;
    last_s = -1;
    case (op)
      OP_START: begin
        tmr_armed[slot] = 1'b1;
        tmr_ivl[slot] = ivl;
        tmr_elapsed[slot] = '0;
        tmr_tag[slot] = tag;
      end
      OP_KILL: tmr_armed[slot] = 1'b0;
      OP_CLEAR: tmr_armed = '0;
      default: begin
        n_ticks++;
        for (int s = 0; s < NSLOTS; s++) begin
          if (tmr_armed[s]) begin
            sum = tmr_elapsed[s] + {17'd0, tmr_step};
            if (sum >= {1'b0, tmr_ivl[s]}) begin
              tmr_elapsed[s] = '0;
              fired[s] = 1'b1;
              last_s = s;
            end else begin
              tmr_elapsed[s] = sum;
            end
          end
        end
        for (int s = 0; s < NSLOTS; s++)
          if (fired[s])
            due_reports.push_back('{slot: s[3:0], tag: tmr_tag[s], last: (s == last_s)});
      end
    endcase
  endfunction

  function automatic void check_report();
    fire_report_t want;
    if (due_reports.size() == 0) begin
      n_mismatch++;
      if (n_mismatch <= ReportMax)
        $display("MISMATCH unexpected report: slot %0d tag %0h last %0b",
                 fired_slot_o, fired_tag_o, last_of_tick_o);
      return;
    end
    want = due_reports.pop_front();
    n_reports++;
    if (fired_slot_o !== want.slot)
      note_mismatch("fired_slot", 64'(want.slot), 64'(fired_slot_o));
    if (fired_tag_o !== want.tag)
      note_mismatch("fired_tag", 64'(want.tag), 64'(fired_tag_o));
    if (last_of_tick_o !== want.last)
      note_mismatch("last_of_tick", 64'(want.last), 64'(last_of_tick_o));
  endfunction

  function automatic int draw_gap(bit on);
    if (!on)
      return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [31:0] rand_interval(logic [15:0] step);
    logic [31:0] span;
    span = {16'd0, step} << 3;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom;
      2: return {16'd0, step};
      default: return $urandom_range(0, span);
    endcase
  endfunction

  // Driver: presents queued words, random gap after each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        run_timer_cmd(op_e'(operation_i), slot_index_i, interval_ms_i, user_tag_i);
        n_cmds_taken++;
        tx_gap = draw_gap(tx_gaps_on);
      end else begin
        tx_gap = tx_wait;
      end
      if (tx_gap == 0 && pending_cmds.size() > 0) begin
        next_cmd = pending_cmds.pop_front();
        operation_i <= next_cmd.op;
        slot_index_i <= next_cmd.slot;
        interval_ms_i <= next_cmd.ivl;
        user_tag_i <= next_cmd.tag;
        in_valid_i <= 1'b1;
        tx_wait <= 0;
      end else begin
        in_valid_i <= 1'b0;
        tx_wait <= (tx_gap > 0) ? tx_gap - 1 : 0;
      end
    end
  end

  // Monitor: checks each fire report, random stalls, one long hold under pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_report();
        rx_next = draw_gap(rx_stalls_on);
      end else begin
        rx_next = (rx_wait > 0) ? rx_wait - 1 : 0;
      end
      if (pressure_on && !hold_done && out_valid_o) begin
        rx_next = HoldCycles;
        hold_done <= 1'b1;
      end
      rx_wait <= rx_next;
      out_ready_i <= (rx_next == 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Timeout: no word moved for %0d cycles", QuietLimit);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic queue_cmd(op_e op, logic [3:0] slot, logic [31:0] ivl, logic [31:0] tag);
    pending_cmds.push_back('{op: op, slot: slot, ivl: ivl, tag: tag});
    n_cmds_queued++;
  endtask

  task automatic random_cmds(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 42)
        queue_cmd(OP_TICK, 4'($urandom), $urandom, $urandom);
      else if (r < 76)
        queue_cmd(OP_START, 4'($urandom_range(0, NSLOTS - 1)), rand_interval(tmr_step),
                  $urandom);
      else if (r < 95)
        queue_cmd(OP_KILL, 4'($urandom_range(0, NSLOTS - 1)), $urandom, $urandom);
      else
        queue_cmd(OP_CLEAR, 4'($urandom), $urandom, $urandom);
    end
  endtask

  // Wait for every word taken and every report seen, then let a tick sweep finish
  task automatic settle();
    while (n_cmds_taken != n_cmds_queued || due_reports.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_tick_step(logic [15:0] want);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_TICK_STEP;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== want)
      note_mismatch("tick_step readback", 64'(want), 64'(prdata[15:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_tick_step(logic [15:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_TICK_STEP;
    pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    tmr_step = value;
    n_settings++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    check_tick_step(value);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_tick_step(StepReset);
    n_settings++;

    // empty table, restart, zero and full-scale intervals
    queue_cmd(OP_TICK, 4'd0, 32'd0, 32'd0);
    queue_cmd(OP_CLEAR, 4'd0, 32'd0, 32'd0);
    queue_cmd(OP_KILL, 4'd5, 32'd0, 32'd0);
    queue_cmd(OP_START, 4'd0, 32'd0, 32'hFFFF_FFFF);
    queue_cmd(OP_START, 4'd15, 32'hFFFF_FFFF, 32'd0);
    queue_cmd(OP_START, 4'd3, 32'd1000, 32'hA5A5_A5A5);
    queue_cmd(OP_TICK, 4'd0, 32'd0, 32'd0);
    queue_cmd(OP_TICK, 4'd0, 32'd0, 32'd0);
    queue_cmd(OP_START, 4'd3, 32'd500, 32'h5A5A_5A5A);
    queue_cmd(OP_START, 4'd9, 32'd499, 32'h1234_5678);
    queue_cmd(OP_TICK, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(OP_KILL, 4'd0, 32'd0, 32'd0);
    queue_cmd(OP_TICK, 4'd0, 32'd0, 32'd0);
    queue_cmd(OP_CLEAR, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(OP_TICK, 4'd0, 32'd0, 32'd0);
    settle();

    // zero step: only zero-interval slots fire
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    set_tick_step(16'd0);
    queue_cmd(OP_START, 4'd2, 32'd0, 32'h0F0F_0F0F);
    queue_cmd(OP_START, 4'd4, 32'd1, 32'hF0F0_F0F0);
    queue_cmd(OP_TICK, 4'd0, 32'd0, 32'd0);
    queue_cmd(OP_TICK, 4'd0, 32'd0, 32'd0);
    queue_cmd(OP_CLEAR, 4'd0, 32'd0, 32'd0);
    settle();

    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    set_tick_step(16'hFFFF);
    random_cmds(48);
    settle();

    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    set_tick_step(16'd1);
    random_cmds(48);
    settle();

    tx_gaps_on = 1'b1;
    set_tick_step(16'($urandom_range(1, 65535)));
    random_cmds(48);
    settle();

    // all slots fire on the six directed ticks; output held off so the sweep backs up
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b1;
    set_tick_step(StepReset);
    pressure_on = 1'b1;
    for (int s = 0; s < NSLOTS; s++)
      queue_cmd(OP_START, s[3:0], $urandom_range(0, 500), $urandom);
    repeat (6) queue_cmd(OP_TICK, 4'($urandom), $urandom, $urandom);
    random_cmds(40);
    settle();

    $display("Ran %0d words (%0d ticks) over %0d tick_step settings, %0d reports checked",
             n_cmds_taken, n_ticks, n_settings, n_reports);
    $display("Long output hold %s, %0d mismatches",
             hold_done ? "applied" : "not reached", n_mismatch);
    if (n_mismatch == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
